[hdl/integer_text_parser_defines.svh]
// Assertion macros for the integer text parser.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef INTEGER_TEXT_PARSER_DEFINES_SVH
`define INTEGER_TEXT_PARSER_DEFINES_SVH

// Expression must hold at every clock edge outside reset.
`define ITP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("itp assertion failed");

// Antecedent in this cycle implies consequent in the next one.
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

[hdl/itp_pkg.sv]
// Shared types and constants for the integer text parser.
// No dependencies; imported by every module of the block.
package itp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int VALUE_WIDTH = 64;
    localparam int BASE_W      = 6;
    localparam int DIGIT_W     = 6;
    localparam int OUT_VALUE_W = 64;
    localparam int OUT_COUNT_W = 16;
    localparam int STATUS_W    = 2;

    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADBASE = 2'd2;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 4'd1;

    localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] NO_DIGIT   = 6'd36;

    localparam logic [VALUE_WIDTH-1:0] VALUE_UMAX = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] VALUE_SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VALUE_SMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

    // One classified character word.
    typedef struct packed {
        logic               first;
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic [DIGIT_W-1:0] digit;
    } item_t;

    typedef struct packed {
        logic [BASE_W-1:0] number_base;
        logic              signed_mode;
    } cfg_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } q_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OUT_COUNT_W-1:0] count;
        logic [OUT_VALUE_W-1:0] value;
    } result_t;

endpackage

[hdl/integer_text_parser.sv]
// Top level of the streaming text-to-integer parser.
// Depends on itp_pkg, itp_front, itp_queue, itp_back and the assertion macros.
//
//  channel  direction  handshake              payload
//  s_       in         s_tvalid / s_tready    s_tdata: text_char; s_tuser: first_char
//  m_       out        m_tvalid / m_tready    m_tdata: parsed_value, chars_consumed,
//                                             parse_status
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One character word per clock while the m_ side takes results; a result is written to
// the result register when its terminating word leaves the queue, and m_tvalid comes
// from that register. The radix multiply-add in the back end is combinational.
// Reset is synchronous (aresetn low); no clearing pass, config resets to base 10,
// signed mode. A stalled m_ side fills the 4-word queue, then drops s_tready.
// Words that give no result still drain while a result waits.
`include "integer_text_parser_defines.svh"

module integer_text_parser import itp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic [0:0]  s_tuser,   // [0] first_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [63:0] parsed_value, [79:64] chars_consumed,
                                   // [81:80] parse_status, [87:82] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BASE_W-1:0]    cfg_data
);

    localparam int M_PAD = 88 - (OUT_VALUE_W + OUT_COUNT_W + STATUS_W);

    // Configuration registers; the user must write them only while the parser is idle (not enforced here).
    logic [BASE_W-1:0] number_base_reg;
    logic              signed_mode_reg;
    cfg_t              cfg;

    item_t   push_item, head_item;
    logic    q_push, q_ready, q_pop, head_valid;
    q_stat_t q_stat;
    result_t res;

    assign cfg_ready       = 1'b1;
    assign cfg.number_base = number_base_reg;
    assign cfg.signed_mode = signed_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= BASE_RESET;
            signed_mode_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NUMBER_BASE: number_base_reg <= cfg_data;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // Front end: classify each character word into the queue.
    itp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    itp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .stat       (q_stat)
    );

    // Back end: parse sequencer and result register.
    itp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res)
    );

    assign m_tdata = {{M_PAD{1'b0}}, res.status, res.count, res.value};

    // Queue never holds more than its depth, and input stalls only when it is full.
    `ITP_ASSERT_ALWAYS(a_q_bound, q_stat.count <= QCNT_W'(Q_DEPTH))
    `ITP_ASSERT_ALWAYS(a_ready_full, s_tready == !q_stat.full)
    // A push without a pop grows the queue by one word.
    `ITP_ASSERT_NEXT(a_q_grow, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)
    // Invalid-base results report no consumed characters.
    `ITP_ASSERT_ALWAYS(a_badbase_count, !(m_tvalid && res.status == ST_BADBASE) || res.count == '0)

endmodule

[hdl/itp_front.sv]
// Front end: takes character words and classifies them for the parser.
// Depends on itp_pkg.
module itp_front import itp_pkg::*; (
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    input  logic       q_ready,
    output logic       q_push,
    output item_t      q_item
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    logic [7:0] c;
    logic [7:0] dtmp;

    assign c        = s_tdata;
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        dtmp = 8'd0;
        q_item.digit = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            dtmp = c - CH_0;
            q_item.digit = dtmp[DIGIT_W-1:0];
        end else if (c >= CH_LA && c <= CH_LZ) begin
            dtmp = c - CH_LA + LETTER_OFS;
            q_item.digit = dtmp[DIGIT_W-1:0];
        end else if (c >= CH_UA && c <= CH_UZ) begin
            dtmp = c - CH_UA + LETTER_OFS;
            q_item.digit = dtmp[DIGIT_W-1:0];
        end
        q_item.first    = s_tuser[0];
        q_item.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        q_item.is_plus  = (c == CH_PLUS);
        q_item.is_minus = (c == CH_MINUS);
        q_item.is_zero  = (c == CH_0);
        q_item.is_x     = (c == CH_LX) || (c == CH_UX);
    end

endmodule

[hdl/itp_queue.sv]
// Short word queue between front end and parser back end.
// Depends on itp_pkg.
module itp_queue import itp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   push_item,
    output logic    push_ready,
    input  logic    pop,
    output logic    head_valid,
    output item_t   head_item,
    output q_stat_t stat
);

    item_t             mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;
    assign stat.count = count_reg;
    assign stat.full  = !push_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/itp_back.sv]
// Back end: parse sequencer, radix multiply-add and result register.
// Depends on itp_pkg.
module itp_back import itp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    head_valid,
    input  item_t   head_item,
    output logic    pop,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    localparam logic [2:0] PH_DONE  = 3'd0;
    localparam logic [2:0] PH_LEAD  = 3'd1;
    localparam logic [2:0] PH_BASE  = 3'd2;
    localparam logic [2:0] PH_ZERO  = 3'd3;
    localparam logic [2:0] PH_HEX0  = 3'd4;
    localparam logic [2:0] PH_HEXX  = 3'd5;
    localparam logic [2:0] PH_DIGIT = 3'd6;

    localparam int PW = VALUE_WIDTH + BASE_W;
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_TWO  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    logic [2:0]             phase_reg, phase_next;
    logic [BASE_W-1:0]      base_reg, base_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic emit;
    logic slot_free;
    logic fire;

    assign slot_free = !out_valid_reg || m_tready;
    assign fire      = head_valid && (!emit || slot_free);
    assign pop       = fire;
    assign m_tvalid  = out_valid_reg;
    assign m_res     = out_reg;

    always_comb begin : seq
        logic [2:0]             ph;
        logic [BASE_W-1:0]      b;
        logic                   ng;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   ovf;
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   active;
        logic                   held;
        logic                   consume;
        logic [VALUE_WIDTH-1:0] ev;
        logic [COUNT_WIDTH-1:0] ec;
        logic [STATUS_W-1:0]    es;
        logic [PW-1:0]          prod;
        logic [PW-1:0]          lim;
        logic                   neg_f;

        ph      = phase_reg;
        b       = base_reg;
        ng      = neg_reg;
        acc     = acc_reg;
        ovf     = ovf_reg;
        cnt     = cnt_reg;
        held    = 1'b0;
        consume = 1'b0;
        emit    = 1'b0;
        ev      = '0;
        ec      = '0;
        es      = ST_OK;
        prod    = '0;
        lim     = '0;
        neg_f   = 1'b0;

        if (head_item.first) begin
            b      = cfg.number_base;
            ng     = 1'b0;
            acc    = '0;
            ovf    = 1'b0;
            cnt    = '0;
            active = 1'b1;
            if (b == BASE_ONE || b > BASE_MAX) begin
                emit = 1'b1;
                held = 1'b1;
                ph   = PH_DONE;
                ev   = cfg.signed_mode ? VALUE_SMAX : VALUE_UMAX;
                es   = ST_BADBASE;
            end else begin
                ph = PH_LEAD;
            end
        end else begin
            active = (ph != PH_DONE);
        end

        // Phases only move forward, so one ordered pass covers fall-through.
        if (active && !held && ph == PH_LEAD) begin
            if (head_item.is_space) begin
                consume = 1'b1;
                held    = 1'b1;
            end else begin
                ph = PH_BASE;
                if (cfg.signed_mode && (head_item.is_plus || head_item.is_minus)) begin
                    ng      = head_item.is_minus;
                    consume = 1'b1;
                    held    = 1'b1;
                end
            end
        end
        if (active && !held && ph == PH_BASE) begin
            if (b == BASE_AUTO) begin
                if (head_item.is_zero) begin
                    consume = 1'b1;
                    held    = 1'b1;
                    ph      = PH_ZERO;
                end else begin
                    b  = BASE_DEC;
                    ph = PH_DIGIT;
                end
            end else begin
                ph = (b == BASE_HEX) ? PH_HEX0 : PH_DIGIT;
            end
        end
        if (active && !held && ph == PH_ZERO) begin
            if (head_item.is_x) begin
                consume = 1'b1;
                held    = 1'b1;
                b       = BASE_HEX;
                ph      = PH_HEX0;
            end else begin
                b  = BASE_OCT;
                ph = PH_DIGIT;
            end
        end
        if (active && !held && ph == PH_HEX0) begin
            ph = PH_DIGIT;
            if (head_item.is_zero) begin
                consume = 1'b1;
                held    = 1'b1;
                ph      = PH_HEXX;
            end
        end
        if (active && !held && ph == PH_HEXX) begin
            ph = PH_DIGIT;
            if (head_item.is_x) begin
                consume = 1'b1;
                held    = 1'b1;
            end
        end
        if (active && !held && ph == PH_DIGIT) begin
            if (b < BASE_TWO || head_item.digit >= b) begin
                // End of number: saturate or apply the sign.
                emit  = 1'b1;
                ph    = PH_DONE;
                ec    = cnt;
                neg_f = cfg.signed_mode && ng;
                if (ovf) begin
                    es = ST_RANGE;
                    ev = !cfg.signed_mode ? VALUE_UMAX : (neg_f ? VALUE_SMIN : VALUE_SMAX);
                end else begin
                    es = ST_OK;
                    ev = neg_f ? (~acc + 1'b1) : acc;
                end
            end else begin
                // Range check on the unwrapped product: acc*b + d > limit.
                prod = PW'(acc) * PW'(b) + PW'(head_item.digit);
                if (!cfg.signed_mode) begin
                    lim = PW'(VALUE_UMAX);
                end else begin
                    lim = ng ? PW'(VALUE_SMIN) : PW'(VALUE_SMAX);
                end
                if (!ovf && prod > lim) begin
                    ovf = 1'b1;
                end
                acc     = prod[VALUE_WIDTH-1:0];
                consume = 1'b1;
            end
        end

        if (consume && cnt != COUNT_MAX) begin
            cnt = cnt + 1'b1;
        end

        phase_next = ph;
        base_next  = b;
        neg_next   = ng;
        acc_next   = acc;
        ovf_next   = ovf;
        cnt_next   = cnt;

        out_next.value  = OUT_VALUE_W'(ev);
        out_next.count  = OUT_COUNT_W'(ec);
        out_next.status = es;
    end

    always_comb begin
        if (fire && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DONE;
            base_reg      <= '0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                cnt_reg   <= cnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_reg <= out_next;
        end
    end

endmodule
